FILE: src/compacting_array_list_assert.svh
// Assertion helpers shared by the list datapath.
`ifndef COMPACTING_ARRAY_LIST_ASSERT_SVH
`define COMPACTING_ARRAY_LIST_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define CAL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define CAL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/cal_pkg.sv
package cal_pkg;

   localparam int LIST_DEPTH  = 16;
   localparam int MAX_RESULTS = 16;
   localparam int DUMP_CAP    = (LIST_DEPTH < MAX_RESULTS) ? LIST_DEPTH : MAX_RESULTS;

   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   // Fixed field widths on the ports
   localparam int CMD_W     = 3;
   localparam int VAL_W     = 32;
   localparam int IDX_IN_W  = 4;
   localparam int STATUS_W  = 3;
   localparam int POS_W     = 4;
   localparam int CNT_OUT_W = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 112;

   localparam int WIDE_W = (CNT_W > IDX_IN_W + 1) ? CNT_W : IDX_IN_W + 1;

   typedef enum logic [CMD_W-1:0] {
      OP_APPEND = 3'd0,
      OP_REMOVE = 3'd1,
      OP_FIND   = 3'd2,
      OP_MINMAX = 3'd3,
      OP_DUMP   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_FULL      = 3'd1,
      STS_BAD_INDEX = 3'd2,
      STS_NOT_FOUND = 3'd3,
      STS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic rd_issue;
      logic advance;
      logic acc_en;
      logic emit_single;
   } ctl_type;

   // Datapath to controller
   typedef struct packed {
      op_type in_op;
      logic   early_err;
      logic   more;
      logic   dv;
      logic   find_hit;
      logic   op_dump;
      logic   out_free;
   } sts_type;

endpackage

FILE: src/compacting_array_list.sv
// Channel | Dir | tdata (low bit up)                          | tuser | tlast
// req     | in  | value[31:0], index[35:32], zero [39:36]     | cmd   | -
// rsp     | out | status[2:0], position[6:3], element[38:7],  | -     | last
//         |     | max_value[70:39], min_value[102:71],        |       |
//         |     | count[107:103], zero [111:108]              |       |
// One command at a time; req_tready is high only while idle.
// Remove, find, min/max and dump walk the table through one RAM read port, one
// entry a cycle, except while a stalled rsp channel holds a dump walk.
// Synchronous active-high reset empties the list; no clearing pass is needed.
// A stalled rsp channel holds the dump walk; the output register lets a new
// command in while the last result still waits.
module compacting_array_list
   import cal_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // value, index
   input  logic [CMD_W-1:0]      req_tuser,  // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // status, position, element, max, min, count
   output logic                  rsp_tlast
);

   ctl_type ctl;
   sts_type sts;

   cal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   cal_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: src/cal_ram.sv
module cal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/cal_dpath.sv
`include "compacting_array_list_assert.svh"

module cal_dpath
   import cal_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl,
   output sts_type               sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   op_type            op_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [IDX_IN_W-1:0] idx_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [CNT_W-1:0]  ptr_ff;
   logic [CNT_W-1:0]  dpos_ff;
   logic              dv_ff;
   logic              found_ff;
   logic [CNT_W-1:0]  fpos_ff;
   logic [VAL_W-1:0]  max_ff;
   logic [VAL_W-1:0]  min_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic [VAL_W-1:0]     rsp_elem_ff;
   logic [VAL_W-1:0]     rsp_max_ff;
   logic [VAL_W-1:0]     rsp_min_ff;
   logic [CNT_OUT_W-1:0] rsp_cnt_ff;
   logic                 rsp_last_ff;

   logic [VAL_W-1:0]    rd_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [VAL_W-1:0]    wr_data;
   logic [CNT_W-1:0]    scan_end;
   logic [WIDE_W-1:0]   start_wide;
   logic                idx_bad;
   logic                list_full;
   logic                out_free;
   logic                emit_dump;
   logic                dump_last;
   status_type          single_status;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign idx_bad   = WIDE_W'(idx_ff) >= WIDE_W'(cnt_ff);
   assign list_full = cnt_ff == CNT_W'(LIST_DEPTH);
   assign scan_end  = (op_ff == OP_DUMP && cnt_ff > CNT_W'(DUMP_CAP)) ?
                      CNT_W'(DUMP_CAP) : cnt_ff;
   assign dump_last = dpos_ff == scan_end - CNT_W'(1);
   assign emit_dump = ctl.acc_en && op_ff == OP_DUMP;

   // remove start: one past the deleted slot
   assign start_wide = (op_type'(req_tuser) == OP_REMOVE) ?
                       WIDE_W'(req_tdata[VAL_W +: IDX_IN_W]) + WIDE_W'(1) : '0;

   assign sts.in_op     = op_type'(req_tuser);
   assign sts.early_err = (op_ff == OP_REMOVE && idx_bad) ||
                          ((op_ff == OP_MINMAX || op_ff == OP_DUMP) && cnt_ff == '0);
   assign sts.more      = ptr_ff < scan_end;
   assign sts.dv        = dv_ff;
   assign sts.find_hit  = op_ff == OP_FIND && rd_data == val_ff;
   assign sts.op_dump   = op_ff == OP_DUMP;
   assign sts.out_free  = out_free;

   // shift write during remove, tail write on append
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[IDX_W-1:0];
      wr_data = val_ff;
      if (ctl.acc_en && op_ff == OP_REMOVE) begin
         wr_en   = 1'b1;
         wr_addr = IDX_W'(dpos_ff - CNT_W'(1));
         wr_data = rd_data;
      end else if (ctl.emit_single && op_ff == OP_APPEND && !list_full) begin
         wr_en = 1'b1;
      end
   end

   cal_ram #(
      .WIDTH (VAL_W),
      .DEPTH (LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_issue),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      cnt_in        = cnt_ff;
      single_status = STS_OK;
      case (op_ff)
         OP_APPEND: begin
            if (list_full) begin
               single_status = STS_FULL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (idx_bad) begin
               single_status = STS_BAD_INDEX;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         OP_FIND:   single_status = found_ff ? STS_OK : STS_NOT_FOUND;
         OP_MINMAX: single_status = (cnt_ff == '0) ? STS_EMPTY : STS_OK;
         OP_DUMP:   single_status = STS_EMPTY;
         default:   single_status = STS_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         dv_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         if (ctl.load) begin
            dv_ff    <= 1'b0;
            found_ff <= 1'b0;
         end else if (ctl.advance) begin
            dv_ff <= ctl.rd_issue;
         end
         if (ctl.acc_en && sts.find_hit) begin
            found_ff <= 1'b1;
         end
         if (ctl.emit_single) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         op_ff  <= op_type'(req_tuser);
         val_ff <= req_tdata[VAL_W-1:0];
         idx_ff <= req_tdata[VAL_W +: IDX_IN_W];
         ptr_ff <= CNT_W'(start_wide);
      end else if (ctl.rd_issue) begin
         ptr_ff  <= ptr_ff + CNT_W'(1);
         dpos_ff <= ptr_ff;
      end
      if (ctl.acc_en) begin
         if (sts.find_hit) begin
            fpos_ff <= dpos_ff;
         end
         if (dpos_ff == '0) begin
            max_ff <= rd_data;
            min_ff <= rd_data;
         end else begin
            if ($signed(rd_data) > $signed(max_ff)) begin
               max_ff <= rd_data;
            end
            if ($signed(rd_data) < $signed(min_ff)) begin
               min_ff <= rd_data;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_dump || ctl.emit_single) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_dump) begin
         rsp_status_ff <= STS_OK;
         rsp_pos_ff    <= POS_W'(dpos_ff);
         rsp_elem_ff   <= rd_data;
         rsp_max_ff    <= '0;
         rsp_min_ff    <= '0;
         rsp_cnt_ff    <= CNT_OUT_W'(cnt_ff);
         rsp_last_ff   <= dump_last;
      end else if (ctl.emit_single) begin
         rsp_status_ff <= single_status;
         rsp_pos_ff    <= (op_ff == OP_FIND && found_ff) ? POS_W'(fpos_ff) : '0;
         rsp_elem_ff   <= '0;
         rsp_max_ff    <= (op_ff == OP_MINMAX && cnt_ff != '0) ? max_ff : '0;
         rsp_min_ff    <= (op_ff == OP_MINMAX && cnt_ff != '0) ? min_ff : '0;
         rsp_cnt_ff    <= CNT_OUT_W'(cnt_in);
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, rsp_cnt_ff, rsp_min_ff, rsp_max_ff, rsp_elem_ff,
                        rsp_pos_ff, rsp_status_ff};

   `CAL_ASSERT_NOW(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CNT_W'(LIST_DEPTH),
      "entry count beyond list depth")
   `CAL_ASSERT_NOW(a_shift_addr, clock, reset, ctl.acc_en && op_ff == OP_REMOVE,
      dpos_ff != '0 && dpos_ff < cnt_ff, "shift write outside the list")
   `CAL_ASSERT_NOW(a_dump_room, clock, reset, emit_dump || ctl.emit_single, out_free,
      "result written over an untaken transaction")
   `CAL_ASSERT_NEXT(a_append_grow, clock, reset,
      ctl.emit_single && op_ff == OP_APPEND && !list_full,
      cnt_ff == $past(cnt_ff) + CNT_W'(1), "append did not grow the list")

endmodule

FILE: src/cal_ctrl.sv
module cal_ctrl
   import cal_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type state_ff;
   state_type state_in;
   logic      stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      // hold the walk while a dumped entry cannot leave
      stall      = sts.op_dump && sts.dv && !sts.out_free;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctl.load   = req_tvalid;
            if (req_tvalid) begin
               if (sts.in_op == OP_APPEND) begin
                  state_in = ST_EMIT;
               end else if (sts.in_op inside {OP_REMOVE, OP_FIND, OP_MINMAX, OP_DUMP}) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sts.early_err) begin
               state_in = ST_EMIT;
            end else if (!stall) begin
               ctl.advance = 1'b1;
               ctl.acc_en  = sts.dv;
               if (sts.dv && sts.find_hit) begin
                  state_in = ST_EMIT;
               end else begin
                  ctl.rd_issue = sts.more;
                  if (!sts.more && !sts.dv) begin
                     state_in = sts.op_dump ? ST_IDLE : ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               ctl.emit_single = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
